FILE: design/ibaf_pkg.sv
package ibaf_pkg;

  // Sizes of the palette and of the coordinate fields.
  localparam int PALETTE_ENTRIES = 256;
  localparam int IDX_BITS        = 8;
  localparam int RAM_ABITS       = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int COORD_BITS      = 12;
  // Clip compares run signed, wide enough for a coordinate and for left + width.
  localparam int CMP_BITS        = ((COORD_BITS > 13) ? COORD_BITS : 13) + 1;

  // Palette entry layout: visible flag over red, green, blue.
  localparam int ENTRY_BITS = 25;

  // Full-scale opacity.
  localparam logic [7:0] FULL_SCALE = 8'hff;

  // Configuration register widths.
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  // Item commands.
  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_BLIT = 2'd1,
    CMD_FILL = 2'd2
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CLIP_LEFT   = 3'd0,
    REG_CLIP_TOP    = 3'd1,
    REG_CLIP_WIDTH  = 3'd2,
    REG_CLIP_HEIGHT = 3'd3,
    REG_KEY_INDEX   = 3'd4,
    REG_FILL_ALPHA  = 3'd5,
    REG_FILL_RGB    = 3'd6
  } cfg_reg_t;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [10:0] clip_left;
    logic [10:0] clip_top;
    logic [11:0] clip_width;
    logic [11:0] clip_height;
    logic [8:0]  key_index;
    logic [7:0]  fill_alpha;
    logic [23:0] fill_rgb;
  } cfg_t;

endpackage

FILE: design/ibaf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
module ibaf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/ibaf_cfg.sv
module ibaf_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [ibaf_pkg::CFG_IDX_BITS-1:0]  wr_index,
  input  logic [ibaf_pkg::CFG_DATA_BITS-1:0] wr_data,
  output ibaf_pkg::cfg_t                     cfg
);

  ibaf_pkg::cfg_t cfg_r;

  // Register file, each register keeps only its own width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_left   <= 11'd0;
      cfg_r.clip_top    <= 11'd0;
      cfg_r.clip_width  <= 12'd2048;
      cfg_r.clip_height <= 12'd2048;
      cfg_r.key_index   <= 9'd256;
      cfg_r.fill_alpha  <= 8'd0;
      cfg_r.fill_rgb    <= 24'd0;
    end else if (wr_en) begin
      case (ibaf_pkg::cfg_reg_t'(wr_index))
        ibaf_pkg::REG_CLIP_LEFT:   cfg_r.clip_left   <= wr_data[10:0];
        ibaf_pkg::REG_CLIP_TOP:    cfg_r.clip_top    <= wr_data[10:0];
        ibaf_pkg::REG_CLIP_WIDTH:  cfg_r.clip_width  <= wr_data[11:0];
        ibaf_pkg::REG_CLIP_HEIGHT: cfg_r.clip_height <= wr_data[11:0];
        ibaf_pkg::REG_KEY_INDEX:   cfg_r.key_index   <= wr_data[8:0];
        ibaf_pkg::REG_FILL_ALPHA:  cfg_r.fill_alpha  <= wr_data[7:0];
        ibaf_pkg::REG_FILL_RGB:    cfg_r.fill_rgb    <= wr_data[23:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: design/indexed_blit_and_alpha_fill_pixel.sv
// Palette blitter with color key and alpha fill. One word per clock in, one result
// word per input word out, in order, via the stage 1 and output registers;
// throughput is one word per cycle unless the output stalls. Load words write the
// 256-entry palette RAM, blit words read it (one read port, registered, so the
// palette lookup sets the two-stage pipeline), and fill words blend the fill color
// over the destination color carried in the word. A load is visible to a blit that
// follows in the very next cycle. A palette entry must be loaded before a blit reads
// it. Configuration writes are always accepted (cfg_ready is tied high) and must be
// made only while no word is in flight.
module indexed_blit_and_alpha_fill_pixel (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input word channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_cmd,
  input  logic signed [ibaf_pkg::COORD_BITS-1:0] in_pos_x,
  input  logic signed [ibaf_pkg::COORD_BITS-1:0] in_pos_y,
  input  logic [ibaf_pkg::IDX_BITS-1:0]        in_color_index,
  input  logic [7:0]                           in_red,
  input  logic [7:0]                           in_green,
  input  logic [7:0]                           in_blue,
  input  logic                                 in_visible,
  // Result word channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_write_enable,
  output logic signed [ibaf_pkg::COORD_BITS-1:0] out_x,
  output logic signed [ibaf_pkg::COORD_BITS-1:0] out_y,
  output logic [7:0]                           out_red,
  output logic [7:0]                           out_green,
  output logic [7:0]                           out_blue,
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ibaf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ibaf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int CB = ibaf_pkg::CMP_BITS;

  ibaf_pkg::cfg_t cfg;

  logic accept;
  logic advance_out;

  // Stage 1 registers.
  logic                                 s1_valid_r, s1_valid_nxt;
  logic [1:0]                           s1_cmd_r;
  logic signed [ibaf_pkg::COORD_BITS-1:0] s1_x_r, s1_y_r;
  logic                                 s1_clip_hit_r;
  logic                                 s1_blit_ok_r;
  logic [15:0]                          s1_prod_fill_r [3];
  logic [15:0]                          s1_prod_dest_r [3];

  // Output registers.
  logic                                 out_valid_r, out_valid_nxt;
  logic                                 out_we_r;
  logic signed [ibaf_pkg::COORD_BITS-1:0] out_x_r, out_y_r;
  logic [7:0]                           out_red_r, out_green_r, out_blue_r;

  logic [ibaf_pkg::ENTRY_BITS-1:0]      pal_rd_data;
  logic                                 idx_in_range;
  logic                                 clip_hit;
  logic                                 key_miss;
  logic [7:0]                           inv_alpha;
  logic [7:0]                           fill_ch [3];
  logic [7:0]                           dest_ch [3];
  logic [7:0]                           blend_ch [3];
  logic                                 we_nxt;
  logic [7:0]                           red_nxt, green_nxt, blue_nxt;

  logic signed [CB-1:0] x_ext, y_ext, left_ext, top_ext, right_ext, bottom_ext;

  // Exact divide by 255 for sums up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] s);
    logic [16:0] t;
    t = 17'(s) + 17'd1 + 17'(s[15:8]);
    return t[15:8];
  endfunction

  // Configuration registers.
  assign cfg_ready = 1'b1;

  ibaf_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Pipeline flow control.
  assign advance_out = !out_valid_r || !out_stall;
  assign in_stall    = s1_valid_r && !advance_out;
  assign accept      = in_valid && !in_stall;

  assign idx_in_range = ({1'b0, in_color_index} <
                         (ibaf_pkg::IDX_BITS + 1)'(ibaf_pkg::PALETTE_ENTRIES));

  // Palette RAM: loads write at acceptance, blits read at acceptance.
  ibaf_ram #(
    .WIDTH (ibaf_pkg::ENTRY_BITS),
    .DEPTH (ibaf_pkg::PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (accept && (in_cmd == ibaf_pkg::CMD_LOAD) && idx_in_range),
    .wr_addr (in_color_index[ibaf_pkg::RAM_ABITS-1:0]),
    .wr_data ({in_visible, in_red, in_green, in_blue}),
    .rd_en   (accept && (in_cmd == ibaf_pkg::CMD_BLIT)),
    .rd_addr (in_color_index[ibaf_pkg::RAM_ABITS-1:0]),
    .rd_data (pal_rd_data)
  );

  // Clip test, done as signed compares wide enough for left plus width.
  assign x_ext      = CB'(in_pos_x);
  assign y_ext      = CB'(in_pos_y);
  assign left_ext   = CB'({1'b0, cfg.clip_left});
  assign top_ext    = CB'({1'b0, cfg.clip_top});
  assign right_ext  = CB'({1'b0, cfg.clip_left}) + CB'({1'b0, cfg.clip_width});
  assign bottom_ext = CB'({1'b0, cfg.clip_top}) + CB'({1'b0, cfg.clip_height});
  assign clip_hit   = (x_ext >= left_ext) && (x_ext < right_ext) &&
                      (y_ext >= top_ext) && (y_ext < bottom_ext);
  assign key_miss   = ({1'b0, in_color_index} != cfg.key_index);

  // Fill operands per channel.
  assign inv_alpha  = ibaf_pkg::FULL_SCALE - cfg.fill_alpha;
  assign fill_ch[0] = cfg.fill_rgb[23:16];
  assign fill_ch[1] = cfg.fill_rgb[15:8];
  assign fill_ch[2] = cfg.fill_rgb[7:0];
  assign dest_ch[0] = in_red;
  assign dest_ch[1] = in_green;
  assign dest_ch[2] = in_blue;

  // Stage 1: capture the word, the clip result and the blend products.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance_out) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r      <= in_cmd;
      s1_x_r        <= in_pos_x;
      s1_y_r        <= in_pos_y;
      s1_clip_hit_r <= clip_hit;
      s1_blit_ok_r  <= clip_hit && idx_in_range && key_miss;
      for (int c = 0; c < 3; c++) begin
        s1_prod_fill_r[c] <= 16'(cfg.fill_alpha) * 16'(fill_ch[c]);
        s1_prod_dest_r[c] <= 16'(inv_alpha) * 16'(dest_ch[c]);
      end
    end
  end

  // Stage 2: sum, divide and select the result color.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      blend_ch[c] = div255(s1_prod_fill_r[c] + s1_prod_dest_r[c]);
    end
    we_nxt    = 1'b0;
    red_nxt   = 8'd0;
    green_nxt = 8'd0;
    blue_nxt  = 8'd0;
    if ((s1_cmd_r == ibaf_pkg::CMD_BLIT) && s1_blit_ok_r && pal_rd_data[24]) begin
      we_nxt    = 1'b1;
      red_nxt   = pal_rd_data[23:16];
      green_nxt = pal_rd_data[15:8];
      blue_nxt  = pal_rd_data[7:0];
    end else if ((s1_cmd_r == ibaf_pkg::CMD_FILL) && s1_clip_hit_r) begin
      we_nxt    = 1'b1;
      red_nxt   = blend_ch[0];
      green_nxt = blend_ch[1];
      blue_nxt  = blend_ch[2];
    end
  end

  // Output register.
  assign out_valid_nxt = advance_out ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_out && s1_valid_r) begin
      out_we_r    <= we_nxt;
      out_x_r     <= s1_x_r;
      out_y_r     <= s1_y_r;
      out_red_r   <= red_nxt;
      out_green_r <= green_nxt;
      out_blue_r  <= blue_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = out_we_r;
  assign out_x            = out_x_r;
  assign out_y            = out_y_r;
  assign out_red          = out_red_r;
  assign out_green        = out_green_r;
  assign out_blue         = out_blue_r;

endmodule

FILE: design/ibaf_checker.sv
module ibaf_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic                                 out_write_enable,
  input logic signed [ibaf_pkg::COORD_BITS-1:0] out_x,
  input logic signed [ibaf_pkg::COORD_BITS-1:0] out_y,
  input logic [7:0]                           out_red,
  input logic [7:0]                           out_green,
  input logic [7:0]                           out_blue
);

  // A pixel that is not written carries black.
  a_unwritten_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_enable) |-> (out_red == 8'd0 && out_green == 8'd0 &&
                                          out_blue == 8'd0))
    else $error("unwritten pixel carries a color");

  // The input is held back only by a stalled result word.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // A result appearing on an empty output came from an accepted word, via stage 1.
  a_rose_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without an accepted word");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_write_enable) &&
      $stable(out_x) && $stable(out_y) && $stable(out_red) &&
      $stable(out_green) && $stable(out_blue)))
    else $error("stalled result word changed");

endmodule

bind indexed_blit_and_alpha_fill_pixel ibaf_checker u_ibaf_checker (.*);

FILE: bench/indexed_blit_and_alpha_fill_pixel_tb.sv
`timescale 1ns / 100ps

module indexed_blit_and_alpha_fill_pixel_tb;

  localparam int DRAIN_CYCLES     = 4;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int WATCHDOG_NS      = 4_000_000;
  localparam logic [8:0] NO_KEY   = 9'd256;

  // One input word as the sender sees it.
  typedef struct {
    ibaf_pkg::cmd_t                         cmd;
    logic signed [ibaf_pkg::COORD_BITS-1:0] x;
    logic signed [ibaf_pkg::COORD_BITS-1:0] y;
    logic [7:0]                             idx;
    logic [7:0]                             r;
    logic [7:0]                             g;
    logic [7:0]                             b;
    logic                                   vis;
  } pixel_word_t;

  // One result word: the pixel write that the block should issue.
  typedef struct packed {
    logic                                   we;
    logic signed [ibaf_pkg::COORD_BITS-1:0] x;
    logic signed [ibaf_pkg::COORD_BITS-1:0] y;
    logic [7:0]                             r;
    logic [7:0]                             g;
    logic [7:0]                             b;
  } pixel_result_t;

  logic                                   clk;
  logic                                   rst_n;
  logic                                   in_valid;
  logic                                   in_stall;
  logic [1:0]                             in_cmd;
  logic signed [ibaf_pkg::COORD_BITS-1:0] in_pos_x;
  logic signed [ibaf_pkg::COORD_BITS-1:0] in_pos_y;
  logic [ibaf_pkg::IDX_BITS-1:0]          in_color_index;
  logic [7:0]                             in_red;
  logic [7:0]                             in_green;
  logic [7:0]                             in_blue;
  logic                                   in_visible;
  logic                                   out_valid;
  logic                                   out_stall;
  logic                                   out_write_enable;
  logic signed [ibaf_pkg::COORD_BITS-1:0] out_x;
  logic signed [ibaf_pkg::COORD_BITS-1:0] out_y;
  logic [7:0]                             out_red;
  logic [7:0]                             out_green;
  logic [7:0]                             out_blue;
  logic                                   cfg_valid;
  logic                                   cfg_ready;
  logic [ibaf_pkg::CFG_IDX_BITS-1:0]      cfg_index;
  logic [ibaf_pkg::CFG_DATA_BITS-1:0]     cfg_data;

  // Shadow copy of the register file.
  logic [10:0] clip_left_q;
  logic [10:0] clip_top_q;
  logic [11:0] clip_width_q;
  logic [11:0] clip_height_q;
  logic [8:0]  key_q;
  logic [7:0]  fill_alpha_q;
  logic [23:0] fill_rgb_q;

  // Shadow palette: visible flag over red, green, blue.
  logic [ibaf_pkg::ENTRY_BITS-1:0] palette_shadow [ibaf_pkg::PALETTE_ENTRIES];
  bit                              palette_loaded [ibaf_pkg::PALETTE_ENTRIES];
  int                              loaded_list[$];

  pixel_result_t expected_pixels[$];

  bit idle_on;
  bit long_hold_req;
  int failures;
  int results_checked;
  int loads_sent;
  int blits_sent;
  int fills_sent;
  int pixels_written;
  int settings_used;
  int input_stall_cycles;
  int output_hold_cycles;

  indexed_blit_and_alpha_fill_pixel u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_color_index   (in_color_index),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .in_visible       (in_visible),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_enable (out_write_enable),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Clip test on full integers, so left + width may run past the coordinate range.
  function automatic bit in_clip(logic signed [ibaf_pkg::COORD_BITS-1:0] x,
                                 logic signed [ibaf_pkg::COORD_BITS-1:0] y);
    int xi, yi, l, t, w, h;
    xi = x;
    yi = y;
    l  = clip_left_q;
    t  = clip_top_q;
    w  = clip_width_q;
    h  = clip_height_q;
    return (xi >= l) && (xi < l + w) && (yi >= t) && (yi < t + h);
  endfunction

  // Blend one channel of the fill color over the destination, truncated.
  function automatic logic [7:0] blend_channel(logic [7:0] fill, logic [7:0] dest);
    int a, f, d, full;
    a    = fill_alpha_q;
    f    = fill;
    d    = dest;
    full = ibaf_pkg::FULL_SCALE;
    return 8'((a * f + d * (full - a)) / full);
  endfunction

  // Pixel write that a word should produce under the current settings.
  function automatic pixel_result_t predict_pixel(pixel_word_t w);
    pixel_result_t res;
    logic [ibaf_pkg::ENTRY_BITS-1:0] entry;
    res   = '0;
    res.x = w.x;
    res.y = w.y;
    case (w.cmd)
      ibaf_pkg::CMD_BLIT: begin
        entry = palette_shadow[w.idx];
        if (in_clip(w.x, w.y) && entry[ibaf_pkg::ENTRY_BITS-1] &&
            ({1'b0, w.idx} != key_q)) begin
          res.we = 1'b1;
          {res.r, res.g, res.b} = entry[23:0];
        end
      end
      ibaf_pkg::CMD_FILL: begin
        if (in_clip(w.x, w.y)) begin
          res.we = 1'b1;
          res.r  = blend_channel(fill_rgb_q[23:16], w.r);
          res.g  = blend_channel(fill_rgb_q[15:8], w.g);
          res.b  = blend_channel(fill_rgb_q[7:0], w.b);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic pixel_word_t make_word(ibaf_pkg::cmd_t c, int x, int y, int idx,
                                            int r, int g, int b, int vis);
    pixel_word_t w;
    w.cmd = c;
    w.x   = x[ibaf_pkg::COORD_BITS-1:0];
    w.y   = y[ibaf_pkg::COORD_BITS-1:0];
    w.idx = idx[7:0];
    w.r   = r[7:0];
    w.g   = g[7:0];
    w.b   = b[7:0];
    w.vis = vis[0];
    return w;
  endfunction

  // Coordinates: full range, around either clip edge, or inside the clip span.
  function automatic logic signed [ibaf_pkg::COORD_BITS-1:0] pick_coord(int lo, int span);
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, (1 << ibaf_pkg::COORD_BITS) - 1);
      1: v = lo + int'($urandom_range(0, 6)) - 3;
      2: v = lo + span + int'($urandom_range(0, 6)) - 3;
      default: v = lo + ((span > 0) ? int'($urandom_range(0, span - 1)) : 0);
    endcase
    return v[ibaf_pkg::COORD_BITS-1:0];
  endfunction

  // Random word; blits only read entries that have been loaded.
  function automatic pixel_word_t random_word();
    pixel_word_t w;
    int pick;
    w.x   = pick_coord(clip_left_q, clip_width_q);
    w.y   = pick_coord(clip_top_q, clip_height_q);
    w.idx = 8'($urandom_range(0, 255));
    w.r   = 8'($urandom_range(0, 255));
    w.g   = 8'($urandom_range(0, 255));
    w.b   = 8'($urandom_range(0, 255));
    w.vis = 1'($urandom_range(0, 1));
    pick  = $urandom_range(0, 99);
    if (pick < 25 || loaded_list.size() == 0) begin
      w.cmd = ibaf_pkg::CMD_LOAD;
    end else if (pick < 65) begin
      w.cmd = ibaf_pkg::CMD_BLIT;
      w.idx = 8'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
      if ($urandom_range(0, 7) == 0 && key_q != NO_KEY && palette_loaded[key_q[7:0]]) begin
        w.idx = key_q[7:0];
      end
    end else begin
      w.cmd = ibaf_pkg::CMD_FILL;
    end
    return w;
  endfunction

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= 10) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endfunction

  // Offer one word and hold it until the block takes it.
  task automatic send_word(pixel_word_t w);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= w.cmd;
    in_pos_x       <= w.x;
    in_pos_y       <= w.y;
    in_color_index <= w.idx;
    in_red         <= w.r;
    in_green       <= w.g;
    in_blue        <= w.b;
    in_visible     <= w.vis;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Accepted at this edge: predict first, then apply any palette load.
    expected_pixels.push_back(predict_pixel(w));
    case (w.cmd)
      ibaf_pkg::CMD_LOAD: begin
        loads_sent++;
        palette_shadow[w.idx] = {w.vis, w.r, w.g, w.b};
        if (!palette_loaded[w.idx]) begin
          palette_loaded[w.idx] = 1'b1;
          loaded_list.push_back(int'(w.idx));
        end
      end
      ibaf_pkg::CMD_BLIT: blits_sent++;
      default:  fills_sent++;
    endcase
  endtask

  // Wait until every expected result has come back and the pipeline is empty.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register; the caller lowers cfg_valid after the last write.
  task automatic write_reg(ibaf_pkg::cfg_reg_t idx, logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ibaf_pkg::REG_CLIP_LEFT:   clip_left_q   = value[10:0];
      ibaf_pkg::REG_CLIP_TOP:    clip_top_q    = value[10:0];
      ibaf_pkg::REG_CLIP_WIDTH:  clip_width_q  = value[11:0];
      ibaf_pkg::REG_CLIP_HEIGHT: clip_height_q = value[11:0];
      ibaf_pkg::REG_KEY_INDEX:   key_q         = value[8:0];
      ibaf_pkg::REG_FILL_ALPHA:  fill_alpha_q  = value[7:0];
      ibaf_pkg::REG_FILL_RGB:    fill_rgb_q    = value[23:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [10:0] left, logic [10:0] top, logic [11:0] wid,
                              logic [11:0] hgt, logic [8:0] key, logic [7:0] alpha,
                              logic [23:0] rgb);
    drain_pipeline();
    write_reg(ibaf_pkg::REG_CLIP_LEFT, 24'(left));
    write_reg(ibaf_pkg::REG_CLIP_TOP, 24'(top));
    write_reg(ibaf_pkg::REG_CLIP_WIDTH, 24'(wid));
    write_reg(ibaf_pkg::REG_CLIP_HEIGHT, 24'(hgt));
    write_reg(ibaf_pkg::REG_KEY_INDEX, 24'(key));
    write_reg(ibaf_pkg::REG_FILL_ALPHA, 24'(alpha));
    write_reg(ibaf_pkg::REG_FILL_RGB, rgb);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Random settings; narrow clips are common so edges get hit often.
  task automatic program_random_setting();
    logic [10:0] left, top;
    logic [11:0] wid, hgt;
    logic [8:0]  key;
    left = 11'($urandom_range(0, 2047));
    top  = 11'($urandom_range(0, 2047));
    wid  = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 8)) :
                                         12'($urandom_range(0, 2048));
    hgt  = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 8)) :
                                         12'($urandom_range(0, 2048));
    if (loaded_list.size() > 0 && $urandom_range(0, 1) == 1) begin
      key = 9'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
    end else begin
      key = ($urandom_range(0, 1) == 1) ? NO_KEY : 9'($urandom_range(0, 255));
    end
    program_regs(left, top, wid, hgt, key, 8'($urandom_range(0, 255)),
                 24'($urandom_range(0, 24'hffffff)));
  endtask

  // Reset settings: full clip from zero, no key, transparent fill.
  task automatic test_reset_state();
    idle_on = 1'b0;
    send_word(make_word(ibaf_pkg::CMD_LOAD, 0, 0, 0, 'hff, 'h00, 'h80, 1));
    // A blit right behind the load of its entry.
    send_word(make_word(ibaf_pkg::CMD_BLIT, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(ibaf_pkg::CMD_LOAD, 0, 0, 255, 'h12, 'h34, 'h56, 1));
    send_word(make_word(ibaf_pkg::CMD_LOAD, 0, 0, 7, 'hff, 'hff, 'hff, 0));
    send_word(make_word(ibaf_pkg::CMD_BLIT, 2047, 2047, 255, 0, 0, 0, 0));
    send_word(make_word(ibaf_pkg::CMD_BLIT, 5, 5, 7, 0, 0, 0, 1));
    send_word(make_word(ibaf_pkg::CMD_BLIT, -1, 0, 0, 0, 0, 0, 0));
    send_word(make_word(ibaf_pkg::CMD_BLIT, -2048, -2048, 255, 0, 0, 0, 0));
    send_word(make_word(ibaf_pkg::CMD_FILL, 100, 100, 0, 'hab, 'hcd, 'hef, 1));
  endtask

  // Clip edges one pixel either side, key match, opaque and half fills, empty clip.
  task automatic test_clip_key_fill();
    idle_on = 1'b1;
    program_regs(11'd100, 11'd200, 12'd50, 12'd1, 9'd0, ibaf_pkg::FULL_SCALE, 24'hffffff);
    send_word(make_word(ibaf_pkg::CMD_BLIT, 100, 200, 0, 0, 0, 0, 0));
    send_word(make_word(ibaf_pkg::CMD_BLIT, 100, 200, 255, 0, 0, 0, 0));
    send_word(make_word(ibaf_pkg::CMD_BLIT, 149, 200, 255, 0, 0, 0, 0));
    send_word(make_word(ibaf_pkg::CMD_BLIT, 150, 200, 255, 0, 0, 0, 0));
    send_word(make_word(ibaf_pkg::CMD_BLIT, 99, 200, 255, 0, 0, 0, 0));
    send_word(make_word(ibaf_pkg::CMD_BLIT, 100, 201, 255, 0, 0, 0, 0));
    send_word(make_word(ibaf_pkg::CMD_BLIT, 100, 199, 255, 0, 0, 0, 0));
    send_word(make_word(ibaf_pkg::CMD_FILL, 120, 200, 0, 0, 0, 0, 0));
    program_regs(11'd2047, 11'd2047, 12'd2048, 12'd2048, 9'd255, 8'd128, 24'h00ff80);
    send_word(make_word(ibaf_pkg::CMD_FILL, 2047, 2047, 0, 'h40, 'hc0, 'hff, 0));
    send_word(make_word(ibaf_pkg::CMD_BLIT, 2047, 2047, 255, 0, 0, 0, 0));
    send_word(make_word(ibaf_pkg::CMD_BLIT, 2047, 2047, 0, 0, 0, 0, 0));
    send_word(make_word(ibaf_pkg::CMD_FILL, 2046, 2047, 0, 'h40, 'hc0, 'hff, 0));
    program_regs(11'd0, 11'd0, 12'd0, 12'd0, NO_KEY, 8'd1, 24'h000000);
    send_word(make_word(ibaf_pkg::CMD_FILL, 0, 0, 0, 'hff, 'hff, 'hff, 1));
    send_word(make_word(ibaf_pkg::CMD_BLIT, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Random traffic over a series of settings, the extremes first.
  task automatic test_random_settings(int phases, int per_phase);
    for (int phase = 0; phase < phases; phase++) begin
      idle_on = (phase % 3 != 1);
      case (phase)
        0: program_regs(11'd0, 11'd0, 12'd2048, 12'd2048, NO_KEY, ibaf_pkg::FULL_SCALE,
                        24'hffffff);
        1: program_regs(11'd2047, 11'd2047, 12'd2048, 12'd2048, 9'd0, 8'd0, 24'h000000);
        2: program_regs(11'd0, 11'd0, 12'd0, 12'd0, 9'd255, 8'd128, 24'h5a5a5a);
        default: program_random_setting();
      endcase
      repeat (per_phase) send_word(random_word());
    end
  endtask

  // The result side holds off for a long stretch while words keep coming.
  task automatic test_output_hold(int count);
    idle_on = 1'b0;
    program_random_setting();
    long_hold_req = 1'b1;
    repeat (count) send_word(random_word());
  endtask

  // Closing stretch at full rate with no idling on either side.
  task automatic test_steady_stream(int count);
    idle_on = 1'b0;
    program_random_setting();
    repeat (count) send_word(random_word());
  endtask

  // Result side stall: random bursts, or one long counted hold on request.
  initial begin : result_backpressure
    int hold_count;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        hold_count = 0;
        while (hold_count < LONG_HOLD_CYCLES) begin
          @(posedge clk);
          hold_count++;
        end
        output_hold_cycles = hold_count;
        long_hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin : result_check
    pixel_result_t got;
    pixel_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.we = out_write_enable;
      got.x  = out_x;
      got.y  = out_y;
      got.r  = out_red;
      got.g  = out_green;
      got.b  = out_blue;
      if (expected_pixels.size() == 0) begin
        note_failure($sformatf("result word with nothing expected: x=%0d y=%0d",
                               got.x, got.y));
      end else begin
        want = expected_pixels.pop_front();
        results_checked++;
        if (got.we) pixels_written++;
        if (got.we !== want.we || got.x !== want.x || got.y !== want.y ||
            got.r !== want.r || got.g !== want.g || got.b !== want.b) begin
          note_failure($sformatf({"mismatch: expected we=%0b x=%0d y=%0d rgb=%02h%02h%02h,",
                                  " got we=%0b x=%0d y=%0d rgb=%02h%02h%02h"},
            want.we, want.x, want.y, want.r, want.g, want.b,
            got.we, got.x, got.y, got.r, got.g, got.b));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (in_valid && in_stall) input_stall_cycles++;
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("Timeout with %0d result words still expected.", expected_pixels.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = ibaf_pkg::CMD_LOAD;
    in_pos_x       = '0;
    in_pos_y       = '0;
    in_color_index = '0;
    in_red         = '0;
    in_green       = '0;
    in_blue        = '0;
    in_visible     = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = ibaf_pkg::REG_CLIP_LEFT;
    cfg_data       = '0;
    idle_on        = 1'b0;
    long_hold_req  = 1'b0;
    clip_left_q    = 11'd0;
    clip_top_q     = 11'd0;
    clip_width_q   = 12'd2048;
    clip_height_q  = 12'd2048;
    key_q          = NO_KEY;
    fill_alpha_q   = 8'd0;
    fill_rgb_q     = 24'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_clip_key_fill();
    test_random_settings(7, 170);
    test_output_hold(64);
    test_steady_stream(250);
    drain_pipeline();

    $display("Run covered %0d loads, %0d blits and %0d fills over %0d register settings.",
             loads_sent, blits_sent, fills_sent, settings_used);
    $display("%0d result words checked, %0d pixels written, input stalled %0d cycles.",
             results_checked, pixels_written, input_stall_cycles);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
design/ibaf_pkg.sv
design/ibaf_ram.sv
design/ibaf_cfg.sv
design/indexed_blit_and_alpha_fill_pixel.sv
design/ibaf_checker.sv
bench/indexed_blit_and_alpha_fill_pixel_tb.sv
